// ===== hw/rtl/f32b_pkg.sv =====
// f32b_pkg: types, constants and fold helpers of the byte-wise fletcher-32 unit
// used by f32b_ifs, f32b_accum, fletcher32_byte_checksum_unit and the testbench; depends on nothing
`timescale 1ns / 1ps

package f32b_pkg;

  localparam int LOW_W  = 18;
  localparam int HIGH_W = 32;
  localparam int CNT_W  = 9;
  localparam int FOLD_W = 17;
  localparam int BYTE_W = 8;
  localparam int SUM_W  = 32;

  localparam logic [LOW_W-1:0]  LOW_INIT  = 18'h0ffff;
  localparam logic [HIGH_W-1:0] HIGH_INIT = 32'h0000ffff;

  // once-folded sums handed from the accumulator to the final fold stage
  typedef struct packed {
    logic [FOLD_W-1:0] low;
    logic [FOLD_W-1:0] high;
  } fold_pair_t;

  // end-around carry: low 16 bits plus the bits above them
  function automatic logic [FOLD_W-1:0] fold_low(input logic [LOW_W-1:0] v);
    return {1'b0, v[15:0]} + {15'b0, v[17:16]};
  endfunction

  function automatic logic [FOLD_W-1:0] fold_high(input logic [HIGH_W-1:0] v);
    return {1'b0, v[15:0]} + {1'b0, v[31:16]};
  endfunction

  function automatic logic [FOLD_W-1:0] fold_17(input logic [FOLD_W-1:0] v);
    return {1'b0, v[15:0]} + {16'b0, v[16]};
  endfunction

endpackage

// ===== hw/rtl/f32b_ifs.sv =====
// f32b_ifs: valid/ready channels of the byte-wise fletcher-32 unit
// byte channel and checksum channel; depend on f32b_pkg for widths
`timescale 1ns / 1ps

interface f32b_in_if;
  logic                         valid;
  logic                         ready;
  logic [f32b_pkg::BYTE_W-1:0]  data_byte;
  logic                         last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface f32b_out_if;
  logic                        valid;
  logic                        ready;
  logic [f32b_pkg::SUM_W-1:0]  checksum;

  modport source (output valid, output checksum, input ready);
  modport sink   (input valid, input checksum, output ready);
endinterface

// ===== hw/rtl/f32b_accum.sv =====
// f32b_accum: running sums, chunk counter and chunk fold of the fletcher-32 unit
// depends on f32b_pkg
`timescale 1ns / 1ps

module f32b_accum #(
  parameter int CHUNK_LEN = 360
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          step,
  input  logic [f32b_pkg::BYTE_W-1:0]   data_byte,
  input  logic                          last_byte,
  output f32b_pkg::fold_pair_t          folded
);

  localparam logic [f32b_pkg::CNT_W-1:0] CHUNK_CNT = f32b_pkg::CNT_W'(CHUNK_LEN);

  logic [f32b_pkg::LOW_W-1:0]  low_r,  low_nxt,  low_add;
  logic [f32b_pkg::HIGH_W-1:0] high_r, high_nxt, high_add;
  logic [f32b_pkg::CNT_W-1:0]  cnt_r,  cnt_nxt,  cnt_inc;
  logic                        fold_now;

  always_comb begin
    low_add  = low_r + {{(f32b_pkg::LOW_W-f32b_pkg::BYTE_W){1'b0}}, data_byte};
    high_add = high_r + {{(f32b_pkg::HIGH_W-f32b_pkg::LOW_W){1'b0}}, low_add};
    cnt_inc  = cnt_r + 1'b1;
    fold_now = last_byte || (cnt_inc >= CHUNK_CNT);

    folded.low  = f32b_pkg::fold_low(low_add);
    folded.high = f32b_pkg::fold_high(high_add);

    low_nxt  = low_r;
    high_nxt = high_r;
    cnt_nxt  = cnt_r;
    if (step) begin
      if (last_byte) begin
        // message done: sums start over
        low_nxt  = f32b_pkg::LOW_INIT;
        high_nxt = f32b_pkg::HIGH_INIT;
        cnt_nxt  = '0;
      end else if (fold_now) begin
        low_nxt  = {1'b0, folded.low};
        high_nxt = {{(f32b_pkg::HIGH_W-f32b_pkg::FOLD_W){1'b0}}, folded.high};
        cnt_nxt  = '0;
      end else begin
        low_nxt  = low_add;
        high_nxt = high_add;
        cnt_nxt  = cnt_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= f32b_pkg::LOW_INIT;
      high_r <= f32b_pkg::HIGH_INIT;
      cnt_r  <= '0;
    end else begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule

// ===== hw/rtl/fletcher32_byte_checksum_unit.sv =====
// fletcher32_byte_checksum_unit: byte-wise fletcher-32 with 0xffff start values
// a last byte passes the input register and the fold stage before its checksum is registered
// throughput: one byte per cycle, one checksum per cycle while out_ch.ready stays high,
//   set by the combinational sum update (byte add, sum2 add, chunk fold) in f32b_accum
// reset (rst_n, synchronous, active low): sums back to 0xffff, chunk count and all valids clear
// depends on f32b_pkg, f32b_ifs and f32b_accum
`timescale 1ns / 1ps

module fletcher32_byte_checksum_unit #(
  parameter int CHUNK_LEN = 360
) (
  input  logic              clk,
  input  logic              rst_n,
  f32b_in_if.sink           in_ch,
  f32b_out_if.source        out_ch
);

  // input register stage
  logic                        a_valid_r, a_valid_nxt;
  logic [f32b_pkg::BYTE_W-1:0] a_byte_r;
  logic                        a_last_r;

  // once-folded sums of a finished message
  logic                        b_valid_r, b_valid_nxt;
  f32b_pkg::fold_pair_t        b_sums_r;

  // result register
  logic                        o_valid_r, o_valid_nxt;
  logic [f32b_pkg::SUM_W-1:0]  o_sum_r;

  f32b_pkg::fold_pair_t        folded;
  logic [f32b_pkg::FOLD_W-1:0] s1, s2;
  logic                        o_free, b_adv, b_free, a_adv, a_free, in_fire;

  // handshake: each stage may take a new item when it is empty or its item moves on
  always_comb begin
    o_free  = !o_valid_r || out_ch.ready;
    b_adv   = b_valid_r && o_free;
    b_free  = !b_valid_r || o_free;
    // a plain byte only touches the sums; a last byte needs room in the fold stage
    a_adv   = a_valid_r && (!a_last_r || b_free);
    a_free  = !a_valid_r || a_adv;
    in_fire = in_ch.valid && a_free;

    a_valid_nxt = in_fire ? 1'b1 : (a_adv ? 1'b0 : a_valid_r);
    b_valid_nxt = (a_adv && a_last_r) ? 1'b1 : (b_adv ? 1'b0 : b_valid_r);
    o_valid_nxt = b_adv ? 1'b1 : (out_ch.ready ? 1'b0 : o_valid_r);
  end

  assign in_ch.ready     = a_free;
  assign out_ch.valid    = o_valid_r;
  assign out_ch.checksum = o_sum_r;

  // running sums, chunk fold every CHUNK_LEN bytes and at the message end
  f32b_accum #(
    .CHUNK_LEN (CHUNK_LEN)
  ) u_accum (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (a_adv),
    .data_byte (a_byte_r),
    .last_byte (a_last_r),
    .folded    (folded)
  );

  // second fold and packing; bit 16 of a folded sum1 lands on bit 16 as in the model
  always_comb begin
    s1 = f32b_pkg::fold_17(b_sums_r.low);
    s2 = f32b_pkg::fold_17(b_sums_r.high);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
      b_valid_r <= b_valid_nxt;
      o_valid_r <= o_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_fire) begin
      a_byte_r <= in_ch.data_byte;
      a_last_r <= in_ch.last_byte;
    end
    if (a_adv && a_last_r) begin
      b_sums_r <= folded;
    end
    if (b_adv) begin
      o_sum_r <= {s2[15:0], 16'h0000} | {15'b0, s1};
    end
  end

  // a last byte waiting on a full fold stage and a stalled result blocks the input
  a_last_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (a_valid_r && a_last_r && b_valid_r && o_valid_r && !out_ch.ready) |-> !in_ch.ready)
    else $error("input taken while a finished message could not move on");

  // the fold stage fills only from a last byte leaving the input register
  b_fill_origin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(b_valid_r) |-> $past(a_adv && a_last_r))
    else $error("fold stage loaded without a message end");

  // a taken result with nothing behind it leaves the output empty
  o_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && out_ch.ready && !b_valid_r) |=> !o_valid_r)
    else $error("checksum repeated after it was taken");

endmodule

// ===== verif/testbench.sv =====
// testbench: self-checking bench for fletcher32_byte_checksum_unit, byte stream in, checksums out
// needs f32b_pkg, f32b_ifs and the rtl of the unit; predicts every checksum and compares in order
`timescale 1ns / 1ps

module testbench;

  localparam int CHUNK_LEN        = 360;
  localparam int RX_HOLD_CYCLES   = 300;   // long receiver hold-off, enough to back the unit up
  localparam int END_QUIET_CYCLES = 8;     // length of the quiet tail at the end of the run

  typedef enum {FILL_RANDOM, FILL_ONES} fill_kind_t;

  typedef struct packed {
    logic [f32b_pkg::BYTE_W-1:0] data;
    logic                        is_last;
  } byte_item_t;

  logic clk = 1'b0;
  logic rst_n;

  f32b_in_if  in_ch ();
  f32b_out_if out_ch ();

  fletcher32_byte_checksum_unit #(
    .CHUNK_LEN (CHUNK_LEN)
  ) u_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // free-running clock, 10 ns period
  always #5 clk = ~clk;

  // bytes waiting to be offered, and checksums waiting to come out
  byte_item_t                  byte_queue[$];
  logic [f32b_pkg::SUM_W-1:0]  expected_sums[$];

  int bytes_queued   = 0;
  int bytes_accepted = 0;
  int mismatch_count = 0;

  // traffic shaping, set by the sequence at falling edges; the hold-off state is kept by the monitor
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  bit rx_hold_request = 1'b0;
  bit rx_hold_taken   = 1'b0;
  int rx_hold_left    = 0;

  // running sums of the message in flight, at the unit's own widths
  logic [f32b_pkg::LOW_W-1:0]  run_low  = f32b_pkg::LOW_INIT;
  logic [f32b_pkg::HIGH_W-1:0] run_high = f32b_pkg::HIGH_INIT;
  logic [f32b_pkg::CNT_W-1:0]  run_count = '0;

  // one byte through the running sums; a marked last byte yields the checksum
  function automatic void advance_checksum(input logic [f32b_pkg::BYTE_W-1:0] data,
                                           input logic is_last,
                                           output bit emits,
                                           output logic [f32b_pkg::SUM_W-1:0] checksum);
    logic [31:0] s1;
    logic [31:0] s2;
    emits    = 1'b0;
    checksum = '0;
    run_low   = run_low + {10'b0, data};
    run_high  = run_high + {14'b0, run_low};
    run_count = run_count + 1'b1;
    // fold on a chunk boundary or at the message end; only once if both coincide
    if (is_last || run_count >= CHUNK_LEN) begin
      run_low   = {2'b0, run_low[15:0]} + {16'b0, run_low[17:16]};
      run_high  = {16'b0, run_high[15:0]} + {16'b0, run_high[31:16]};
      run_count = '0;
    end
    if (is_last) begin
      // second fold; a carry left in bit 16 of s1 overlaps the upper half, one in bit 16 of s2 drops out
      s1 = {16'b0, run_low[15:0]} + {30'b0, run_low[17:16]};
      s2 = {16'b0, run_high[15:0]} + {16'b0, run_high[31:16]};
      checksum  = (s2 << 16) | s1;
      emits     = 1'b1;
      run_low   = f32b_pkg::LOW_INIT;
      run_high  = f32b_pkg::HIGH_INIT;
      run_count = '0;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    $display("%0t ns  mismatch: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic queue_byte(input logic [f32b_pkg::BYTE_W-1:0] data, input logic is_last);
    byte_queue.push_back('{data: data, is_last: is_last});
    bytes_queued++;
  endtask

  // a run of bytes, closed as a message or left open for the next run
  task automatic queue_run(input int len, input fill_kind_t kind, input bit ends_message);
    logic [f32b_pkg::BYTE_W-1:0] b;
    for (int i = 0; i < len; i++) begin
      b = (kind == FILL_ONES) ? 8'hff : 8'($urandom_range(255));
      queue_byte(b, ends_message && (i == len - 1));
    end
  endtask

  // mostly short messages, some medium, a few longer ones
  function automatic int pick_message_len();
    int roll;
    roll = $urandom_range(99);
    if (roll < 85)
      return $urandom_range(24, 1);
    else if (roll < 97)
      return $urandom_range(60, 25);
    else
      return $urandom_range(120, 61);
  endfunction

  // every queued byte taken and every checksum out
  task automatic wait_drained();
    while (bytes_accepted != bytes_queued || expected_sums.size() != 0)
      @(posedge clk);
  endtask

  task automatic run_random_phase(input int idle_pct, input int stall_pct, input int n_bytes);
    int target;
    @(negedge clk);
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    target = bytes_queued + n_bytes;
    while (bytes_queued < target)
      queue_run(pick_message_len(), FILL_RANDOM, 1'b1);
    wait_drained();
  endtask

  // byte driver: predicts on acceptance, then offers the next byte or idles
  always @(posedge clk) begin
    byte_item_t                 next_item;
    bit                         emits;
    logic [f32b_pkg::SUM_W-1:0] checksum;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        advance_checksum(in_ch.data_byte, in_ch.last_byte, emits, checksum);
        if (emits)
          expected_sums.push_back(checksum);
        bytes_accepted++;
      end
      // a new item may only replace one that was taken, or fill an empty slot
      if (!in_ch.valid || in_ch.ready) begin
        if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_item = byte_queue.pop_front();
          in_ch.valid     <= 1'b1;
          in_ch.data_byte <= next_item.data;
          in_ch.last_byte <= next_item.is_last;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // checksum monitor: compares against the oldest prediction, then sets ready
  always @(posedge clk) begin
    logic [f32b_pkg::SUM_W-1:0] want;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_sums.size() == 0) begin
          report_mismatch($sformatf("checksum %08h with nothing expected", out_ch.checksum));
        end else begin
          want = expected_sums.pop_front();
          if (out_ch.checksum !== want)
            report_mismatch($sformatf("checksum %08h, expected %08h", out_ch.checksum, want));
        end
      end
      // one long hold-off when asked for, counted here, otherwise random stalls
      if (rx_hold_request && !rx_hold_taken) begin
        rx_hold_taken <= 1'b1;
        rx_hold_left  <= RX_HOLD_CYCLES;
        out_ch.ready  <= 1'b0;
      end else if (rx_hold_left != 0) begin
        rx_hold_left <= rx_hold_left - 1;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // stimulus sequence
  initial begin
    rst_n           = 1'b0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    in_ch.last_byte = 1'b0;
    out_ch.ready    = 1'b0;

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // directed: one-byte messages at both extremes of the byte
    @(negedge clk);
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hff, 1'b1);
    // two bytes with single bits set
    queue_byte(8'h01, 1'b0);
    queue_byte(8'h80, 1'b1);
    // all ones, sums climb fastest
    queue_run(6, FILL_ONES, 1'b1);
    // zeros only, sum1 stays at its start value while sum2 still grows
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b0);
    queue_byte(8'h00, 1'b1);
    // alternating bit patterns, then single bits clear
    queue_byte(8'h55, 1'b0);
    queue_byte(8'haa, 1'b0);
    queue_byte(8'h7f, 1'b0);
    queue_byte(8'hfe, 1'b1);
    queue_run(3, FILL_RANDOM, 1'b1);

    // chunk boundaries: chunk ending on the last byte, then two chunks and one past
    queue_run(CHUNK_LEN, FILL_ONES, 1'b1);
    queue_run(2 * CHUNK_LEN + 1, FILL_RANDOM, 1'b1);
    queue_run(1, FILL_RANDOM, 1'b1);
    wait_drained();

    // random messages under each idling pattern
    run_random_phase(0, 0, 100);
    run_random_phase(62, 0, 100);
    run_random_phase(0, 62, 100);
    run_random_phase(8, 8, 100);

    // back-pressure: receiver holds off while the sender keeps offering at full rate
    @(negedge clk);
    send_idle_pct   = 0;
    recv_stall_pct  = 0;
    rx_hold_request = 1'b1;
    queue_run(100, FILL_RANDOM, 1'b1);
    repeat (40) queue_run($urandom_range(3, 1), FILL_RANDOM, 1'b1);
    // open a message and stop mid-way until every checksum so far is out
    queue_run(60, FILL_RANDOM, 1'b0);
    wait_drained();
    @(negedge clk);
    queue_run(30, FILL_ONES, 1'b1);
    wait_drained();

    // quiet tail: anything arriving now is unexpected
    repeat (END_QUIET_CYCLES) @(posedge clk);
    if (mismatch_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #3_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/f32b_pkg.sv
hw/rtl/f32b_ifs.sv
hw/rtl/f32b_accum.sv
hw/rtl/fletcher32_byte_checksum_unit.sv
verif/testbench.sv
